[hw/rtl/nrs_pkg.sv]
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types, codes and IEEE 754 helper functions for the Newton-Raphson
// square root block.
// ----------------------------------------------------------------------------
package nrs_pkg;

    localparam int EXP_W        = 14;
    localparam int MAN_W        = 64;
    localparam int STEP_W       = 6;
    localparam int CNT_W        = 8;
    localparam int MAX_ITER_DEF = 32;

    typedef logic signed [EXP_W-1:0] exp_t;
    typedef logic [MAN_W-1:0]        man_t;

    localparam logic FMT_DOUBLE = 1'b0;
    localparam logic FMT_SINGLE = 1'b1;

    localparam exp_t EMIN_DP = -exp_t'(1022);
    localparam exp_t EMAX_DP = exp_t'(1023);
    localparam exp_t BIAS_DP = exp_t'(1023);
    localparam exp_t EMIN_SP = -exp_t'(126);
    localparam exp_t EMAX_SP = exp_t'(127);
    localparam exp_t BIAS_SP = exp_t'(127);

    localparam logic [10:0] GUESS_BIAS_DP = 11'h1FF;
    localparam logic [7:0]  GUESS_BIAS_SP = 8'h3F;

    // sqrt(2) significands, hidden bit at the top
    localparam man_t SQRT2_DP_MAN = 64'hB504_F333_F9DE_6800;
    localparam man_t SQRT2_SP_MAN = 64'hB504_F300_0000_0000;

    localparam logic [63:0] ONE_DP = 64'h3FF0_0000_0000_0000;
    localparam logic [31:0] ONE_SP = 32'h3F80_0000;

    // datapath operations
    localparam logic [4:0] OP_NOP         = 5'd0;
    localparam logic [4:0] OP_LOAD        = 5'd1;
    localparam logic [4:0] OP_GUESS       = 5'd2;
    localparam logic [4:0] OP_UNP_A_OPND  = 5'd3;
    localparam logic [4:0] OP_UNP_A_X     = 5'd4;
    localparam logic [4:0] OP_UNP_B_X     = 5'd5;
    localparam logic [4:0] OP_UNP_B_Q     = 5'd6;
    localparam logic [4:0] OP_NORM        = 5'd7;
    localparam logic [4:0] OP_MUL_INIT    = 5'd8;
    localparam logic [4:0] OP_MUL_STEP    = 5'd9;
    localparam logic [4:0] OP_MUL_FIN     = 5'd10;
    localparam logic [4:0] OP_DIV_INIT    = 5'd11;
    localparam logic [4:0] OP_DIV_STEP    = 5'd12;
    localparam logic [4:0] OP_DIV_FIN     = 5'd13;
    localparam logic [4:0] OP_ADD_ALIGN   = 5'd14;
    localparam logic [4:0] OP_ADD_SUM     = 5'd15;
    localparam logic [4:0] OP_DENORM      = 5'd16;
    localparam logic [4:0] OP_ROUND       = 5'd17;
    localparam logic [4:0] OP_STORE_X     = 5'd18;
    localparam logic [4:0] OP_STORE_Q     = 5'd19;
    localparam logic [4:0] OP_SPECIAL_SUM = 5'd20;
    localparam logic [4:0] OP_UPDATE      = 5'd21;
    localparam logic [4:0] OP_EMIT        = 5'd22;

    // what the result beat carries
    localparam logic [1:0] KIND_X    = 2'd0;
    localparam logic [1:0] KIND_A    = 2'd1;
    localparam logic [1:0] KIND_ZERO = 2'd2;

    typedef struct packed {
        logic [4:0]       op;
        logic [1:0]       kind;
        logic             err;
        logic [CNT_W-1:0] count;
    } nrs_cmd_t;

    typedef struct packed {
        logic opnd_trivial;
        logic opnd_error;
        logic guess_even;
        logic x_zero;
        logic x_special;
        logic q_zero;
        logic q_inf;
        logic norm_done;
        logic x_equal;
    } nrs_stat_t;

    typedef struct packed {
        exp_t e;
        man_t m;
    } unp_t;

    typedef struct packed {
        man_t m;
        logic s;
    } shr_t;

    function automatic logic exp_ones(input logic fmt, input logic [63:0] b);
        return (fmt == FMT_SINGLE) ? (&b[30:23]) : (&b[62:52]);
    endfunction

    function automatic logic mag_zero(input logic fmt, input logic [63:0] b);
        return (fmt == FMT_SINGLE) ? (b[30:0] == '0) : (b[62:0] == '0);
    endfunction

    function automatic unp_t unpack(input logic fmt, input logic [63:0] b);
        unp_t u;
        if (fmt == FMT_SINGLE) begin
            u.m = {(b[30:23] != '0), b[22:0], 40'b0};
            u.e = (b[30:23] == '0) ? EMIN_SP : exp_t'({6'b0, b[30:23]}) - BIAS_SP;
        end
        else begin
            u.m = {(b[62:52] != '0), b[51:0], 11'b0};
            u.e = (b[62:52] == '0) ? EMIN_DP : exp_t'({3'b0, b[62:52]}) - BIAS_DP;
        end
        return u;
    endfunction

    function automatic logic [63:0] guess(input logic fmt, input logic [63:0] a);
        logic [10:0] ed;
        logic [7:0]  es;
        ed = {1'b0, a[62:53]} + GUESS_BIAS_DP;
        es = {1'b0, a[30:24]} + GUESS_BIAS_SP;
        return (fmt == FMT_SINGLE) ? {32'b0, 1'b0, es, 1'b0, a[22:1]}
                                   : {1'b0, ed, 1'b0, a[51:1]};
    endfunction

    function automatic logic [63:0] halve(input logic fmt, input logic [63:0] b);
        return (fmt == FMT_SINGLE) ? {32'b0, b[31], b[30:23] - 8'd1, b[22:0]}
                                   : {b[63], b[62:52] - 11'd1, b[51:0]};
    endfunction

    function automatic logic [63:0] quiet(input logic fmt, input logic [63:0] b);
        logic [63:0] r;
        r = b;
        if (fmt == FMT_SINGLE) begin
            if (exp_ones(fmt, b) && (b[22:0] != '0))
                r[22] = 1'b1;
        end
        else begin
            if (exp_ones(fmt, b) && (b[51:0] != '0))
                r[51] = 1'b1;
        end
        return r;
    endfunction

    function automatic shr_t shr_sticky(input man_t m, input logic [EXP_W-1:0] d);
        shr_t r;
        if (d >= EXP_W'(MAN_W)) begin
            r.m = '0;
            r.s = (m != '0);
        end
        else begin
            r.m = m >> d[STEP_W-1:0];
            r.s = ((m & ~({MAN_W{1'b1}} << d[STEP_W-1:0])) != '0);
        end
        return r;
    endfunction

    // Round to nearest even and pack; operand is positive and already
    // brought up to the minimum exponent.
    function automatic logic [63:0] round_pack(input logic fmt, input exp_t e,
                                               input man_t m, input logic s);
        logic [53:0] kd;
        logic [24:0] ks;
        logic        up;
        exp_t        ee;
        logic [63:0] r;
        ee = e;
        if (fmt == FMT_SINGLE) begin
            kd = '0;
            ks = {1'b0, m[63:40]};
            up = m[39] & ((m[38:0] != '0) | s | m[40]);
            ks = ks + 25'(up);
            if (ks[24]) begin
                ks = ks >> 1;
                ee = e + exp_t'(1);
            end
            if (ee > EMAX_SP)
                r = {32'b0, 1'b0, 8'hFF, 23'b0};
            else
                r = {32'b0, 1'b0, ks[23] ? 8'(ee + BIAS_SP) : 8'b0, ks[22:0]};
        end
        else begin
            ks = '0;
            kd = {1'b0, m[63:11]};
            up = m[10] & ((m[9:0] != '0) | s | m[11]);
            kd = kd + 54'(up);
            if (kd[53]) begin
                kd = kd >> 1;
                ee = e + exp_t'(1);
            end
            if (ee > EMAX_DP)
                r = {1'b0, 11'h7FF, 52'b0};
            else
                r = {1'b0, kd[52] ? 11'(ee + BIAS_DP) : 11'b0, kd[51:0]};
        end
        return r;
    endfunction

endpackage

[hw/rtl/nrs_req_if.sv]
// ----------------------------------------------------------------------------
// nrs_req_if
// Request channel: format and operand pattern, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrs_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] operand_bits;

    modport source (output valid, output req_type, output operand_bits, input ready);
    modport sink   (input valid, input req_type, input operand_bits, output ready);
endinterface

[hw/rtl/nrs_rsp_if.sv]
// ----------------------------------------------------------------------------
// nrs_rsp_if
// Response channel: root pattern, format, step count and error flag.
// ----------------------------------------------------------------------------
interface nrs_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        result_type;
    logic [7:0]  iteration_count;
    logic        error_flag;

    modport source (output valid, output result_bits, output result_type,
                    output iteration_count, output error_flag, input ready);
    modport sink   (input valid, input result_bits, input result_type,
                    input iteration_count, input error_flag, output ready);
endinterface

[hw/rtl/nrs_dp.sv]
// ----------------------------------------------------------------------------
// nrs_dp
// Datapath: operand and iterate registers, bit-serial multiply and divide,
// aligned add, denormalize and round-to-nearest-even packing.
// ----------------------------------------------------------------------------
module nrs_dp
    import nrs_pkg::*;
(
    input  logic        clk,
    input  nrs_cmd_t    cmd,
    input  logic        in_type,
    input  logic [63:0] in_bits,
    output nrs_stat_t   stat,
    output logic [63:0] result_bits,
    output logic        result_type,
    output logic [7:0]  iteration_count,
    output logic        error_flag
);

    logic        fmt_reg;
    logic [63:0] a_reg;
    logic [63:0] x_reg;
    logic [63:0] q_reg;
    logic [63:0] r_reg;
    exp_t        ua_e_reg, ub_e_reg, rn_e_reg;
    man_t        ua_m_reg, ub_m_reg, rn_m_reg;
    man_t        quo_reg;
    logic [MAN_W:0] wk_reg;
    logic        stk_reg;
    logic [63:0] res_bits_reg;
    logic        res_type_reg;
    logic [7:0]  res_cnt_reg;
    logic        res_err_reg;

    logic [MAN_W:0] mul_sum;
    logic [MAN_W:0] div_sub;
    logic           div_ge;
    logic [MAN_W:0] add_sum;
    exp_t           emin;
    shr_t           align;
    shr_t           den;
    logic [63:0]    x_half;

    always_comb
    begin
        mul_sum = {1'b0, wk_reg[MAN_W-1:0]} + (quo_reg[0] ? {1'b0, ua_m_reg} : '0);
        div_ge  = (wk_reg >= {1'b0, ub_m_reg});
        div_sub = wk_reg - {1'b0, ub_m_reg};
        add_sum = {1'b0, ua_m_reg} + {1'b0, ub_m_reg};
        emin    = (fmt_reg == FMT_SINGLE) ? EMIN_SP : EMIN_DP;
        if (ua_e_reg >= ub_e_reg)
            align = shr_sticky(ub_m_reg, EXP_W'(ua_e_reg - ub_e_reg));
        else
            align = shr_sticky(ua_m_reg, EXP_W'(ub_e_reg - ua_e_reg));
        den    = shr_sticky(rn_m_reg, EXP_W'(emin - rn_e_reg));
        x_half = halve(fmt_reg, r_reg);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                fmt_reg <= in_type;
                a_reg   <= in_bits;
            end
            OP_GUESS:
                x_reg <= guess(fmt_reg, a_reg);
            OP_UNP_A_OPND:
                {ua_e_reg, ua_m_reg} <= unpack(fmt_reg, a_reg);
            OP_UNP_A_X:
                {ua_e_reg, ua_m_reg} <= unpack(fmt_reg, x_reg);
            OP_UNP_B_X:
                {ub_e_reg, ub_m_reg} <= unpack(fmt_reg, x_reg);
            OP_UNP_B_Q:
                {ub_e_reg, ub_m_reg} <= unpack(fmt_reg, q_reg);
            OP_NORM:
            begin
                // one bit a cycle for subnormal inputs
                if (!ua_m_reg[MAN_W-1])
                begin
                    ua_m_reg <= ua_m_reg << 1;
                    ua_e_reg <= ua_e_reg - exp_t'(1);
                end
                if (!ub_m_reg[MAN_W-1])
                begin
                    ub_m_reg <= ub_m_reg << 1;
                    ub_e_reg <= ub_e_reg - exp_t'(1);
                end
            end
            OP_MUL_INIT:
            begin
                wk_reg  <= '0;
                quo_reg <= (fmt_reg == FMT_SINGLE) ? SQRT2_SP_MAN : SQRT2_DP_MAN;
                stk_reg <= 1'b0;
            end
            OP_MUL_STEP:
            begin
                wk_reg  <= {1'b0, mul_sum[MAN_W:1]};
                stk_reg <= stk_reg | mul_sum[0];
                quo_reg <= quo_reg >> 1;
            end
            OP_MUL_FIN:
            begin
                // hold the sticky gathered over the product steps
                if (wk_reg[MAN_W-1])
                begin
                    rn_m_reg <= wk_reg[MAN_W-1:0];
                    rn_e_reg <= ua_e_reg + exp_t'(1);
                end
                else
                begin
                    rn_m_reg <= {wk_reg[MAN_W-2:0], 1'b0};
                    rn_e_reg <= ua_e_reg;
                end
            end
            OP_DIV_INIT:
            begin
                wk_reg  <= {1'b0, ua_m_reg};
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                quo_reg <= {quo_reg[MAN_W-2:0], div_ge};
                wk_reg  <= div_ge ? {div_sub[MAN_W-1:0], 1'b0} : {wk_reg[MAN_W-1:0], 1'b0};
            end
            OP_DIV_FIN:
            begin
                stk_reg <= (wk_reg != '0);
                if (quo_reg[MAN_W-1])
                begin
                    rn_m_reg <= quo_reg;
                    rn_e_reg <= ua_e_reg - ub_e_reg;
                end
                else
                begin
                    rn_m_reg <= {quo_reg[MAN_W-2:0], 1'b0};
                    rn_e_reg <= ua_e_reg - ub_e_reg - exp_t'(1);
                end
            end
            OP_ADD_ALIGN:
            begin
                // larger exponent into A, aligned smaller into B
                if (ua_e_reg < ub_e_reg)
                begin
                    ua_e_reg <= ub_e_reg;
                    ua_m_reg <= ub_m_reg;
                end
                ub_m_reg <= align.m;
                stk_reg  <= align.s;
            end
            OP_ADD_SUM:
            begin
                if (add_sum[MAN_W])
                begin
                    rn_m_reg <= add_sum[MAN_W:1];
                    rn_e_reg <= ua_e_reg + exp_t'(1);
                    stk_reg  <= stk_reg | add_sum[0];
                end
                else
                begin
                    rn_m_reg <= add_sum[MAN_W-1:0];
                    rn_e_reg <= ua_e_reg;
                end
            end
            OP_DENORM:
            begin
                if (rn_e_reg < emin)
                begin
                    rn_m_reg <= den.m;
                    stk_reg  <= stk_reg | den.s;
                    rn_e_reg <= emin;
                end
            end
            OP_ROUND:
                r_reg <= round_pack(fmt_reg, rn_e_reg, rn_m_reg, stk_reg);
            OP_STORE_X:
                x_reg <= r_reg;
            OP_STORE_Q:
                q_reg <= r_reg;
            OP_SPECIAL_SUM:
            begin
                if (exp_ones(fmt_reg, x_reg))
                    r_reg <= quiet(fmt_reg, x_reg);
                else if (exp_ones(fmt_reg, q_reg))
                    r_reg <= q_reg;
                else
                    r_reg <= x_reg;
            end
            OP_UPDATE:
                x_reg <= x_half;
            OP_EMIT:
            begin
                // single results carry zeros above bit 31
                case (cmd.kind)
                    KIND_X:
                        res_bits_reg <= (fmt_reg == FMT_SINGLE) ? {32'b0, x_reg[31:0]}
                                                                : x_reg;
                    KIND_A:
                        res_bits_reg <= (fmt_reg == FMT_SINGLE) ? {32'b0, a_reg[31:0]}
                                                                : a_reg;
                    default:
                        res_bits_reg <= '0;
                endcase
                res_type_reg <= fmt_reg;
                res_cnt_reg  <= cmd.count;
                res_err_reg  <= cmd.err;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (fmt_reg == FMT_SINGLE)
        begin
            stat.opnd_trivial = (a_reg[30:0] == '0) || (a_reg[31:0] == ONE_SP);
            stat.opnd_error   = a_reg[31] || exp_ones(fmt_reg, a_reg);
            stat.guess_even   = !a_reg[23];
        end
        else
        begin
            stat.opnd_trivial = (a_reg[62:0] == '0) || (a_reg == ONE_DP);
            stat.opnd_error   = a_reg[63] || exp_ones(fmt_reg, a_reg);
            stat.guess_even   = !a_reg[52];
        end
        stat.x_zero    = mag_zero(fmt_reg, x_reg);
        stat.x_special = exp_ones(fmt_reg, x_reg);
        stat.q_zero    = mag_zero(fmt_reg, q_reg);
        stat.q_inf     = exp_ones(fmt_reg, q_reg);
        stat.norm_done = ua_m_reg[MAN_W-1] && ub_m_reg[MAN_W-1];
        stat.x_equal   = (x_half == x_reg);
    end

    assign result_bits     = res_bits_reg;
    assign result_type     = res_type_reg;
    assign iteration_count = res_cnt_reg;
    assign error_flag      = res_err_reg;

endmodule

[hw/rtl/nrs_ctrl.sv]
// ----------------------------------------------------------------------------
// nrs_ctrl
// Controller: sequences classify, guess and sqrt(2) multiply, then the divide,
// add, round and update steps of each Newton-Raphson pass, and owns both handshakes.
// ----------------------------------------------------------------------------
module nrs_ctrl
    import nrs_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  nrs_stat_t stat,
    output nrs_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLASS    = 5'd1;
    localparam logic [4:0] S_MUL_UA   = 5'd2;
    localparam logic [4:0] S_MUL_INIT = 5'd3;
    localparam logic [4:0] S_MUL_STEP = 5'd4;
    localparam logic [4:0] S_MUL_FIN  = 5'd5;
    localparam logic [4:0] S_DEN      = 5'd6;
    localparam logic [4:0] S_RND      = 5'd7;
    localparam logic [4:0] S_POST     = 5'd8;
    localparam logic [4:0] S_ITER     = 5'd9;
    localparam logic [4:0] S_DIV_UB   = 5'd10;
    localparam logic [4:0] S_DIV_NORM = 5'd11;
    localparam logic [4:0] S_DIV_INIT = 5'd12;
    localparam logic [4:0] S_DIV_STEP = 5'd13;
    localparam logic [4:0] S_DIV_FIN  = 5'd14;
    localparam logic [4:0] S_ADD_CHK  = 5'd15;
    localparam logic [4:0] S_ADD_UB   = 5'd16;
    localparam logic [4:0] S_ADD_NORM = 5'd17;
    localparam logic [4:0] S_ADD_ALGN = 5'd18;
    localparam logic [4:0] S_ADD_SUM  = 5'd19;
    localparam logic [4:0] S_UPDATE   = 5'd20;
    localparam logic [4:0] S_FIN      = 5'd21;

    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_DIV = 2'd1;
    localparam logic [1:0] PH_ADD = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAN_W - 1);

    logic [4:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [1:0]        kind_reg, kind_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = OP_NOP;
        cmd.kind       = kind_reg;
        cmd.err        = err_reg;
        cmd.count      = n_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    n_next     = '0;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (stat.opnd_trivial)
                begin
                    kind_next  = KIND_A;
                    err_next   = 1'b0;
                    state_next = S_FIN;
                end
                else if (stat.opnd_error)
                begin
                    kind_next  = KIND_ZERO;
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_GUESS;
                    state_next = stat.guess_even ? S_MUL_UA : S_ITER;
                end
            end
            S_MUL_UA:
            begin
                cmd.op     = OP_UNP_A_X;
                state_next = S_MUL_INIT;
            end
            S_MUL_INIT:
            begin
                cmd.op     = OP_MUL_INIT;
                step_next  = '0;
                state_next = S_MUL_STEP;
            end
            S_MUL_STEP:
            begin
                cmd.op    = OP_MUL_STEP;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                    state_next = S_MUL_FIN;
            end
            S_MUL_FIN:
            begin
                cmd.op     = OP_MUL_FIN;
                phase_next = PH_MUL;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = OP_DENORM;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.op     = OP_ROUND;
                state_next = S_POST;
            end
            S_POST:
            begin
                case (phase_reg)
                    PH_MUL:
                    begin
                        cmd.op     = OP_STORE_X;
                        state_next = S_ITER;
                    end
                    PH_DIV:
                    begin
                        cmd.op     = OP_STORE_Q;
                        state_next = S_ADD_CHK;
                    end
                    default:
                        state_next = S_UPDATE;
                endcase
            end
            S_ITER:
            begin
                if (stat.x_zero)
                begin
                    kind_next  = KIND_X;
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if (stat.x_special)
                begin
                    cmd.op     = OP_SPECIAL_SUM;
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.op     = OP_UNP_A_OPND;
                    state_next = S_DIV_UB;
                end
            end
            S_DIV_UB:
            begin
                cmd.op     = OP_UNP_B_X;
                state_next = S_DIV_NORM;
            end
            S_DIV_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.norm_done)
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                step_next  = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op    = OP_DIV_STEP;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN:
            begin
                cmd.op     = OP_DIV_FIN;
                phase_next = PH_DIV;
                state_next = S_DEN;
            end
            S_ADD_CHK:
            begin
                if (stat.q_zero || stat.q_inf)
                begin
                    cmd.op     = OP_SPECIAL_SUM;
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.op     = OP_UNP_A_X;
                    state_next = S_ADD_UB;
                end
            end
            S_ADD_UB:
            begin
                cmd.op     = OP_UNP_B_Q;
                state_next = S_ADD_NORM;
            end
            S_ADD_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.norm_done)
                    state_next = S_ADD_ALGN;
            end
            S_ADD_ALGN:
            begin
                cmd.op     = OP_ADD_ALIGN;
                state_next = S_ADD_SUM;
            end
            S_ADD_SUM:
            begin
                cmd.op     = OP_ADD_SUM;
                phase_next = PH_ADD;
                state_next = S_DEN;
            end
            S_UPDATE:
            begin
                cmd.op    = OP_UPDATE;
                n_next    = n_reg + CNT_W'(1);
                kind_next = KIND_X;
                if (stat.x_equal)
                begin
                    err_next   = 1'b0;
                    state_next = S_FIN;
                end
                else if (n_next >= CNT_W'(MAX_ITER))
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                    state_next = S_ITER;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MUL;
            step_reg      <= '0;
            n_reg         <= '0;
            kind_reg      <= KIND_X;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            kind_reg      <= kind_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/ieee_newton_raphson_sqrt.sv]
// ----------------------------------------------------------------------------
// ieee_newton_raphson_sqrt
// Square root of one IEEE 754 single or double value by Newton-Raphson
// iteration, every operation rounded to nearest even in the operand's format.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  req     | in  | req_type, operand_bits
//  rsp     | out | result_bits, result_type, iteration_count, error_flag
//
//  One beat at a time. Zero, one and error operands skip the iteration. A
//  general operand runs the sqrt(2) scaling (even exponent only) and then
//  Newton steps, each dominated by the bit-serial 64-step divider; a
//  subnormal operand adds one normalization shift per leading zero in every
//  step. rsp is held in an output register: a new req beat is taken while
//  the previous result waits, and the block stalls only at the end of an
//  item whose predecessor is still unread. rst_n clears control state only.
// ----------------------------------------------------------------------------
module ieee_newton_raphson_sqrt
    import nrs_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    nrs_req_if.sink  req,
    nrs_rsp_if.source rsp
);

    nrs_cmd_t  cmd;
    nrs_stat_t stat;

    // sequencer: walks each step, drives both valid/ready pairs
    nrs_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic: shared multiply/divide/add/round unit and result register
    nrs_dp u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .in_type         (req.req_type),
        .in_bits         (req.operand_bits),
        .stat            (stat),
        .result_bits     (rsp.result_bits),
        .result_type     (rsp.result_type),
        .iteration_count (rsp.iteration_count),
        .error_flag      (rsp.error_flag)
    );

endmodule
